/* hdl/rwc_pkg.sv */
// shared types and verdict codes for the replay window check
package rwc_pkg;

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_OK      = 2'd0;
  localparam verdict_t VERDICT_DUP     = 2'd1;
  localparam verdict_t VERDICT_TOO_OLD = 2'd2;

  localparam int CNT_W = 32;

endpackage

/* hdl/rwc_window.sv */
// window state (largest counter and seen map) with the per-beat check
module rwc_window #(
  parameter int WINDOW = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      chk_en,
  input  logic [rwc_pkg::CNT_W-1:0] counter,
  output rwc_pkg::verdict_t         verdict
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // bit i of seen_map flags counter (largest - i)
  logic [rwc_pkg::CNT_W-1:0] largest, largest_next;
  logic [WINDOW-1:0]         seen_map, seen_map_next;

  logic                      too_old, ahead, far, dup;
  logic [rwc_pkg::CNT_W-1:0] gap, diff;

  always_comb begin
    too_old = ({1'b0, counter} + (rwc_pkg::CNT_W+1)'(WINDOW)) <= {1'b0, largest};
    ahead   = counter > largest;
    gap     = counter - largest;
    diff    = largest - counter;
    far     = gap >= rwc_pkg::CNT_W'(WINDOW);
    dup     = !ahead && seen_map[diff[IW-1:0]];

    largest_next  = largest;
    seen_map_next = seen_map;
    if (too_old) begin
      verdict = rwc_pkg::VERDICT_TOO_OLD;
    end else if (dup) begin
      verdict = rwc_pkg::VERDICT_DUP;
    end else begin
      verdict = rwc_pkg::VERDICT_OK;
      if (ahead) begin
        largest_next = counter;
        // slide window up by the gap, flags falling out are dropped
        seen_map_next = far ? '0 : (seen_map << gap[IW-1:0]);
        seen_map_next[0] = 1'b1;
      end else begin
        seen_map_next[diff[IW-1:0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      largest  <= '0;
      seen_map <= '0;
    end else if (chk_en) begin
      largest  <= largest_next;
      seen_map <= seen_map_next;
    end
  end

endmodule

/* hdl/replay_window_check_top.sv */
// top level of the sliding window replay check
// One result beat per counter beat. A beat sits in an input register, is
// checked against the window state by one pass of compare, subtract and
// shift logic, and lands in the result register once that register is
// empty or being drained. A new counter can be taken every cycle while
// the output side is not stalled; the window state (largest counter plus
// a WINDOW-bit seen map) is updated as each beat is checked. Verdicts:
// accepted, duplicate, too old (at or below largest minus WINDOW). Reset
// clears the window; there is no clearing pass, so the block is ready in
// the first cycle after reset.
module replay_window_check_top #(
  parameter int WINDOW = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rwc_pkg::CNT_W-1:0] counter,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      accepted,
  output rwc_pkg::verdict_t         verdict
);

  // input register stage
  logic                      stg_valid;
  logic [rwc_pkg::CNT_W-1:0] stg_counter;

  // check happens when the staged beat moves into the result register
  logic              move;
  rwc_pkg::verdict_t chk_verdict;

  assign move     = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || move;

  rwc_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .chk_en  (move),
    .counter (stg_counter),
    .verdict (chk_verdict)
  );

  // handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_valid <= in_valid;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_counter <= counter;
    end
    if (move) begin
      verdict  <= chk_verdict;
      accepted <= (chk_verdict == rwc_pkg::VERDICT_OK);
    end
  end

endmodule

/* hdl/replay_window_check_sva.sv */
// port-level checker for the replay window check, bound to the top level
module replay_window_check_sva (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              accepted,
  input rwc_pkg::verdict_t verdict
);

  // flag and code must agree on every result beat
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (verdict == rwc_pkg::VERDICT_OK)))
    else $error("accepted flag disagrees with verdict");

  // unused code never appears
  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == rwc_pkg::VERDICT_OK || verdict == rwc_pkg::VERDICT_DUP ||
                   verdict == rwc_pkg::VERDICT_TOO_OLD))
    else $error("illegal verdict code");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(accepted))
    else $error("result beat changed while stalled");

  // no result beat straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a drained output side always frees the input
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind replay_window_check_top replay_window_check_sva u_sva (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .accepted  (accepted),
  .verdict   (verdict)
);
